### hw/rtl/vts_pkg.sv
// Shared types and constants for the VLAN tag strip / classify block.
// No dependencies; used by the interfaces and every module in hw/rtl.
package vts_pkg;

   localparam int unsigned POS_W   = 5;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned TPID_W  = 16;
   localparam int unsigned VID_W   = 12;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned RUN_MAX = 3;

   // Frame positions of interest
   localparam logic [POS_W-1:0] POS_TAG0 = 5'd12;  // first TPID byte
   localparam logic [POS_W-1:0] POS_TAG1 = 5'd13;  // second TPID byte
   localparam logic [POS_W-1:0] POS_TCI0 = 5'd14;  // first TCI byte
   localparam logic [POS_W-1:0] POS_TCI1 = 5'd15;  // second TCI byte
   localparam logic [POS_W-1:0] POS_PASS = 5'd16;  // past the tag, saturates

   localparam logic [VID_W-1:0] VID_MASK = 12'hfff;

   localparam logic [TPID_W-1:0] TPID_PRIMARY_RST   = 16'h8100;
   localparam logic [TPID_W-1:0] TPID_SECONDARY_RST = 16'h88a8;

   // CSR register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TPID_PRIMARY   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TPID_SECONDARY = 1'd1;

   typedef logic [BYTE_W-1:0] byte_type;

   // Up to three output words caused by one input word.
   typedef struct packed {
      logic [1:0]                  count;
      logic [RUN_MAX-1:0][BYTE_W-1:0] bytes;
      logic [RUN_MAX-1:0]          present;
      logic                        frame_end;  // applies to the last word
      logic [VID_W-1:0]            gate;
   } run_type;

   typedef struct packed {
      logic can_load;   // a new run may be loaded this cycle
      logic last;       // word on the output is the last of its run
   } ser_status_type;

endpackage

### hw/rtl/vts_if.sv
// Channel interfaces for the VLAN tag strip / classify block.
// Depends on vts_pkg for field widths.
interface vts_req_if;
   logic                       valid;
   logic                       ready;
   logic [vts_pkg::BYTE_W-1:0] data_byte;
   logic                       frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface vts_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [vts_pkg::BYTE_W-1:0] out_byte;
   logic                       byte_present;
   logic                       out_frame_end;
   logic [vts_pkg::VID_W-1:0]  gate;
   logic                       run_end;

   modport source (output valid, output out_byte, output byte_present,
                   output out_frame_end, output gate, output run_end, input ready);
   modport sink   (input valid, input out_byte, input byte_present,
                   input out_frame_end, input gate, input run_end, output ready);
endinterface

interface vts_csr_if;
   logic                          valid;
   logic                          ready;
   logic [vts_pkg::CSR_IDX_W-1:0] index;
   logic [vts_pkg::TPID_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/vts_parse.sv
// Frame position tracking, TPID match and run building for one input word.
// Depends on vts_pkg.
module vts_parse (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [vts_pkg::BYTE_W-1:0]  data_byte,
   input  logic                        frame_end,
   input  logic [vts_pkg::TPID_W-1:0]  tpid_primary,
   input  logic [vts_pkg::TPID_W-1:0]  tpid_secondary,
   output vts_pkg::run_type            run
);

   logic [vts_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic                       tag_seen_ff, tag_seen_in;
   logic [vts_pkg::VID_W-1:0]  vid_ff, vid_in;
   logic [vts_pkg::BYTE_W-1:0] held0_ff, held0_in;
   logic [vts_pkg::BYTE_W-1:0] held1_ff, held1_in;
   logic [vts_pkg::BYTE_W-1:0] held2_ff, held2_in;
   logic [vts_pkg::TPID_W-1:0] tpid;
   logic                       match;

   assign tpid  = {held0_ff, data_byte};
   assign match = (tpid == tpid_primary) || (tpid == tpid_secondary);

   always_comb begin
      pos_in      = pos_ff;
      tag_seen_in = tag_seen_ff;
      vid_in      = vid_ff;
      held0_in    = held0_ff;
      held1_in    = held1_ff;
      held2_in    = held2_ff;
      run         = '0;

      if (pos_ff < vts_pkg::POS_TAG0 || pos_ff >= vts_pkg::POS_PASS) begin
         run.count      = 2'd1;
         run.bytes[0]   = data_byte;
         run.present[0] = 1'b1;
         run.frame_end  = frame_end;
         run.gate       = tag_seen_ff ? vid_ff : '0;
         pos_in = (pos_ff < vts_pkg::POS_PASS) ? pos_ff + 5'd1 : vts_pkg::POS_PASS;
      end else if (pos_ff == vts_pkg::POS_TAG0) begin
         held0_in = data_byte;
         if (frame_end) begin
            run.count      = 2'd1;
            run.bytes[0]   = data_byte;
            run.present[0] = 1'b1;
            run.frame_end  = 1'b1;
         end else begin
            pos_in = vts_pkg::POS_TAG1;
         end
      end else if (pos_ff == vts_pkg::POS_TAG1) begin
         held1_in = data_byte;
         if (frame_end || !match) begin
            // release both TPID bytes: the held one and this one
            run.count     = 2'd2;
            run.bytes[0]  = held0_ff;
            run.bytes[1]  = data_byte;
            run.present   = 3'b011;
            run.frame_end = frame_end;
            pos_in        = vts_pkg::POS_PASS;
         end else begin
            tag_seen_in = 1'b1;
            pos_in      = vts_pkg::POS_TCI0;
         end
      end else if (pos_ff == vts_pkg::POS_TCI0) begin
         held2_in = data_byte;
         if (frame_end) begin
            // tag cut short: frame goes out unchanged
            run.count     = 2'd3;
            run.bytes[0]  = held0_ff;
            run.bytes[1]  = held1_ff;
            run.bytes[2]  = data_byte;
            run.present   = 3'b111;
            run.frame_end = 1'b1;
         end else begin
            pos_in = vts_pkg::POS_TCI1;
         end
      end else begin
         vid_in = {held2_ff[3:0], data_byte} & vts_pkg::VID_MASK;
         if (frame_end) begin
            // end-only marker carries the VLAN ID
            run.count     = 2'd1;
            run.frame_end = 1'b1;
            run.gate      = vid_in;
         end else begin
            pos_in = vts_pkg::POS_PASS;
         end
      end

      if (frame_end) begin
         pos_in      = '0;
         tag_seen_in = 1'b0;
         vid_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         tag_seen_ff <= 1'b0;
         vid_ff      <= '0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         tag_seen_ff <= tag_seen_in;
         vid_ff      <= vid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         held2_ff <= held2_in;
      end
   end

endmodule

### hw/rtl/vts_serial.sv
// Result register: holds a run of up to three words, sends one per ready cycle.
// Depends on vts_pkg and vts_if.
module vts_serial (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  vts_pkg::run_type       run,
   output vts_pkg::ser_status_type status,
   vts_rsp_if.source              rsp
);

   logic [1:0]                                   count_ff, count_in;
   logic [vts_pkg::RUN_MAX-1:0][vts_pkg::BYTE_W-1:0] bytes_ff, bytes_in;
   logic [vts_pkg::RUN_MAX-1:0]                  present_ff, present_in;
   logic                                         fend_ff, fend_in;
   logic [vts_pkg::VID_W-1:0]                    gate_ff, gate_in;
   logic                                         take;
   logic                                         last;

   assign last = (count_ff == 2'd1);
   assign take = rsp.valid && rsp.ready;

   assign status.last     = last;
   assign status.can_load = (count_ff == 2'd0) || (last && rsp.ready);

   assign rsp.valid         = (count_ff != 2'd0);
   assign rsp.out_byte      = bytes_ff[0];
   assign rsp.byte_present  = present_ff[0];
   assign rsp.out_frame_end = fend_ff && last;
   assign rsp.gate          = (fend_ff && last) ? gate_ff : '0;
   assign rsp.run_end       = last;

   always_comb begin
      count_in   = count_ff;
      bytes_in   = bytes_ff;
      present_in = present_ff;
      fend_in    = fend_ff;
      gate_in    = gate_ff;
      if (load) begin
         count_in   = run.count;
         bytes_in   = run.bytes;
         present_in = run.present;
         fend_in    = run.frame_end;
         gate_in    = run.gate;
      end else if (take) begin
         count_in   = count_ff - 2'd1;
         bytes_in   = {8'h00, bytes_ff[2:1]};
         present_in = {1'b0, present_ff[2:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff   <= bytes_in;
      present_ff <= present_in;
      fend_ff    <= fend_in;
      gate_ff    <= gate_in;
   end

endmodule

### hw/rtl/vlan_tag_strip_classify.sv
// VLAN tag strip / classify: byte stream in, tag-stripped stream plus VLAN ID out.
// Depends on vts_pkg, vts_if, vts_parse and vts_serial.
//
// Usage:
//   req  - one frame word per handshake: data_byte and frame_end (last byte).
//   rsp  - output words: out_byte/byte_present, out_frame_end with gate (the
//          VLAN ID, 0 if untagged) and run_end on the last word caused by
//          one input word.
//   csr  - register writes (index 0: primary TPID, index 1: secondary TPID);
//          always ready, write only while the block is idle.
// The first word of a run is on rsp in the cycle after the input word is taken.
// Each input word makes zero to three output words, sent one per cycle from
// the result register while rsp.ready is high; a new input word is taken
// every cycle while each run is a single word and rsp.ready is high; a run
// of two or three words holds req.ready low until its last word is taken.
// Tag bytes 12..15 of a tagged frame give no output bytes if it runs past byte 14.
// Reset: position and tag state cleared, TPIDs return to 0x8100 / 0x88a8,
// result register empty.
// Stall: when rsp.ready is low the current word holds and req.ready drops
// once the pending word is not the last of its run or is stalled.
module vlan_tag_strip_classify (
   input  logic        clock,
   input  logic        reset,
   vts_req_if.sink     req,
   vts_rsp_if.source   rsp,
   vts_csr_if.sink     csr
);

   logic [vts_pkg::TPID_W-1:0] tpid_primary_ff;
   logic [vts_pkg::TPID_W-1:0] tpid_secondary_ff;
   logic                       accept;
   vts_pkg::run_type           run;
   vts_pkg::ser_status_type    ser_status;

   assign csr.ready = 1'b1;
   assign req.ready = ser_status.can_load;
   assign accept    = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpid_primary_ff   <= vts_pkg::TPID_PRIMARY_RST;
         tpid_secondary_ff <= vts_pkg::TPID_SECONDARY_RST;
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            vts_pkg::CSR_TPID_PRIMARY:   tpid_primary_ff   <= csr.data;
            vts_pkg::CSR_TPID_SECONDARY: tpid_secondary_ff <= csr.data;
            default: ;
         endcase
      end
   end

   vts_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req.data_byte),
      .frame_end      (req.frame_end),
      .tpid_primary   (tpid_primary_ff),
      .tpid_secondary (tpid_secondary_ff),
      .run            (run)
   );

   vts_serial u_serial (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .run    (run),
      .status (ser_status),
      .rsp    (rsp)
   );

   // frame end always closes its run
   a_fend_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.out_frame_end) |-> rsp.run_end)
      else $error("frame end not on last word of run");

   // an end-only marker must close the frame
   a_marker_end: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.byte_present) |-> rsp.out_frame_end)
      else $error("empty word without frame end");

   // a new word is only taken when the pending run is done
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |-> (!rsp.valid || (rsp.ready && ser_status.last)))
      else $error("input taken over a pending run");

   // a stalled word holds its place in the run
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.run_end)))
      else $error("stalled run changed");

endmodule

### verif/vlan_tag_strip_classify_tb.sv
`timescale 1ns / 1ps
// Testbench for vlan_tag_strip_classify: sends Ethernet frames a byte per word,
// predicts the stripped stream and VLAN ID, and checks every output word.
// Depends on vts_pkg, the vts_*_if interfaces and the block's RTL.
module vlan_tag_strip_classify_tb;
   import vts_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned MAX_GAP       = 4;
   localparam int unsigned PRINT_LIMIT   = 40;

   typedef struct packed {
      byte_type         data;
      logic             present;
      logic             frame_last;
      logic [VID_W-1:0] vid;
      logic             run_last;
   } out_word_type;

   logic clock = 1'b0;
   logic reset;
   logic no_gaps = 1'b0;

   vts_req_if req_if();
   vts_rsp_if rsp_if();
   vts_csr_if csr_if();

   vlan_tag_strip_classify u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source),
      .csr   (csr_if.sink)
   );

   out_word_type pending_words[$];
   int unsigned  errors = 0;
   int unsigned  frames_sent = 0;
   int unsigned  bytes_sent = 0;
   int unsigned  words_seen = 0;
   int unsigned  settings_used = 0;
   int unsigned  cycle_count = 0;

   // predicted parser state
   logic [POS_W-1:0]  frame_pos;
   byte_type          held [3];
   logic              tag_hit;
   logic [VID_W-1:0]  frame_vid;
   logic [TPID_W-1:0] tpid_primary;
   logic [TPID_W-1:0] tpid_secondary;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still expected",
                  cycle_count, pending_words.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("MISMATCH cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   function automatic out_word_type make_word(input byte_type data, input logic present,
                                              input logic last, input logic [VID_W-1:0] vid);
      out_word_type w;
      w.data       = data;
      w.present    = present;
      w.frame_last = last;
      w.vid        = last ? vid : '0;
      w.run_last   = 1'b0;
      return w;
   endfunction

   // Works out the output words caused by one accepted input byte.
   task automatic predict_strip(input byte_type b, input logic last);
      out_word_type      run [$];
      logic [TPID_W-1:0] tpid;
      if (frame_pos < POS_TAG0 || frame_pos >= POS_PASS) begin
         run.push_back(make_word(b, 1'b1, last, tag_hit ? frame_vid : '0));
         if (frame_pos < POS_PASS)
            frame_pos = frame_pos + 1'b1;
      end else if (frame_pos == POS_TAG0) begin
         held[0] = b;
         if (last)
            run.push_back(make_word(b, 1'b1, 1'b1, '0));
         else
            frame_pos = POS_TAG1;
      end else if (frame_pos == POS_TAG1) begin
         held[1] = b;
         tpid = {held[0], b};
         if (last) begin
            run.push_back(make_word(held[0], 1'b1, 1'b0, '0));
            run.push_back(make_word(b, 1'b1, 1'b1, '0));
         end else if (tpid == tpid_primary || tpid == tpid_secondary) begin
            tag_hit   = 1'b1;
            frame_pos = POS_TCI0;
         end else begin
            run.push_back(make_word(held[0], 1'b1, 1'b0, '0));
            run.push_back(make_word(b, 1'b1, 1'b0, '0));
            frame_pos = POS_PASS;
         end
      end else if (frame_pos == POS_TCI0) begin
         held[2] = b;
         if (last) begin
            run.push_back(make_word(held[0], 1'b1, 1'b0, '0));
            run.push_back(make_word(held[1], 1'b1, 1'b0, '0));
            run.push_back(make_word(b, 1'b1, 1'b1, '0));
         end else begin
            frame_pos = POS_TCI1;
         end
      end else begin
         frame_vid = VID_MASK & {held[2][3:0], b};
         // tag complete at the last byte: end-only marker carries the VID
         if (last)
            run.push_back(make_word('0, 1'b0, 1'b1, frame_vid));
         else
            frame_pos = POS_PASS;
      end
      if (last) begin
         frame_pos = '0;
         tag_hit   = 1'b0;
         frame_vid = '0;
      end
      if (run.size() > 0)
         run[run.size()-1].run_last = 1'b1;
      foreach (run[i])
         pending_words.push_back(run[i]);
   endtask

   task automatic send_byte(input byte_type b, input logic last);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.frame_end <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_strip(b, last);
      bytes_sent++;
   endtask

   // Bytes 12..15 carry the type field and TCI; the rest are random.
   task automatic send_frame(input int unsigned len, input logic [15:0] type_field,
                             input logic [15:0] tci);
      byte_type b;
      for (int unsigned i = 0; i < len; i++) begin
         case (i)
            12: b = type_field[15:8];
            13: b = type_field[7:0];
            14: b = tci[15:8];
            15: b = tci[7:0];
            default: b = byte_type'($urandom_range(0, 255));
         endcase
         send_byte(b, i == len - 1);
      end
      frames_sent++;
   endtask

   // Stop sending and let every expected word drain out.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [TPID_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      if (idx == CSR_TPID_PRIMARY)
         tpid_primary = value;
      else
         tpid_secondary = value;
   endtask

   task automatic program_tpids(input logic [TPID_W-1:0] primary,
                                input logic [TPID_W-1:0] secondary);
      wait_idle();
      write_csr(CSR_TPID_PRIMARY, primary);
      write_csr(CSR_TPID_SECONDARY, secondary);
      csr_if.valid <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic test_default_tpids();
      send_frame(16, 16'h8100, 16'h0fff);   // tag is the frame's tail
      send_frame(17, 16'h88a8, 16'hefff);   // service tag, PCP/DEI masked off
   endtask

   task automatic test_short_frames();
      send_frame(1, 16'h8100, 16'h0001);
      send_frame(13, 16'h8100, 16'h0001);   // ends on first type byte
      send_frame(14, 16'h8100, 16'h0001);   // ends on second type byte, matching
      send_frame(15, 16'h88a8, 16'h0abc);   // tagged, ends inside the TCI
   endtask

   task automatic test_tpid_extremes();
      program_tpids(16'h0000, 16'hffff);
      send_frame(16, 16'hffff, 16'h0000);
      program_tpids(16'hffff, 16'h0000);
      send_frame(16, 16'h0000, 16'hf00f);
   endtask

   task automatic test_back_to_back();
      no_gaps = 1'b1;
      program_tpids(16'h9100, 16'h8100);
      send_frame(17, 16'h9100, 16'h0321);
      send_frame(15, 16'h0800, 16'h4500);   // untagged, type bytes released
      wait_idle();
      no_gaps = 1'b0;
   endtask

   task automatic test_random_frames();
      logic [TPID_W-1:0] primary, secondary;
      int unsigned       start_bytes, kind, len;
      logic [15:0]       type_field;
      primary   = TPID_W'($urandom_range(0, 16'hffff));
      secondary = ($urandom_range(0, 3) == 0) ? primary
                                               : TPID_W'($urandom_range(0, 16'hffff));
      program_tpids(primary, secondary);
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < 24) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            type_field = $urandom_range(0, 1) ? primary : secondary;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 15)
                                              : $urandom_range(16, 24);
         end else if (kind <= 7) begin
            type_field = 16'($urandom_range(0, 16'hffff));
            len = $urandom_range(13, 24);
         end else if (kind == 8) begin
            type_field = primary;
            len = $urandom_range(1, 12);
         end else begin
            // near miss: one bit off a programmed type
            type_field = primary ^ (16'h1 << $urandom_range(0, 15));
            len = $urandom_range(14, 20);
         end
         send_frame(len, type_field, 16'($urandom_range(0, 16'hffff)));
      end
      no_gaps = 1'b0;
   endtask

   // Result side: random stall before each word.
   initial begin
      int unsigned stall;
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_words
      out_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         words_seen++;
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word byte 0x%0h end %0b",
                                      rsp_if.out_byte, rsp_if.out_frame_end));
         end else begin
            want = pending_words.pop_front();
            check_field("out_byte", 16'(rsp_if.out_byte), 16'(want.data));
            check_field("byte_present", 16'(rsp_if.byte_present), 16'(want.present));
            check_field("out_frame_end", 16'(rsp_if.out_frame_end), 16'(want.frame_last));
            check_field("gate", 16'(rsp_if.gate), 16'(want.vid));
            check_field("run_end", 16'(rsp_if.run_end), 16'(want.run_last));
         end
      end
   end

   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= '0;
      req_if.frame_end <= 1'b0;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= CSR_TPID_PRIMARY;
      csr_if.data      <= '0;
      frame_pos      = '0;
      tag_hit        = 1'b0;
      frame_vid      = '0;
      tpid_primary   = TPID_PRIMARY_RST;
      tpid_secondary = TPID_SECONDARY_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_tpids();
      test_short_frames();
      test_tpid_extremes();
      test_back_to_back();
      test_random_frames();
      wait_idle();

      $display("Sent %0d frames (%0d bytes) under %0d TPID settings plus reset defaults",
               frames_sent, bytes_sent, settings_used);
      $display("Checked %0d output words, %0d mismatches", words_seen, errors);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
